### sv/dehed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehed_pkg
// Shared types and constants of the digital-input edge/hold event detector.
// ----------------------------------------------------------------------------
package dehed_pkg;

    // Number of monitored input ports (1 to 8)
    localparam int NUM_PORTS   = 8;
    localparam int PORT_IDX_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Field widths
    localparam int PORT_W      = 3;
    localparam int TIME_W      = 32;
    localparam int HOLD_W      = 32;
    localparam int SLACK_W     = 20;
    localparam int MODES_W     = 16;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 3;
    localparam int NUM_HOLD_REGS = 4;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    // Constants
    localparam logic [SLACK_W-1:0] SLACK_RESET = SLACK_W'(24000);
    localparam logic [HOLD_W-1:0]  HOLD_MIN_MS = HOLD_W'(40);
    localparam logic [HOLD_W-1:0]  HOLD_MAX_MS = HOLD_W'(3600000);

    // Per-port detection mode
    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_RISE  = 2'd1,
        MODE_FALL  = 2'd2,
        MODE_ANY   = 2'd3
    } port_mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PORT_MODES = 3'd0,
        CFG_HOLD_01    = 3'd1,
        CFG_HOLD_23    = 3'd2,
        CFG_HOLD_45    = 3'd3,
        CFG_HOLD_67    = 3'd4,
        CFG_SLACK      = 3'd5
    } cfg_index_t;

    // Per-port state word held in the state RAM
    typedef struct packed {
        logic [TIME_W-1:0] arm_time;
        logic              timing_active;
        logic              last_level;
    } port_state_t;

    localparam int STATE_W = $bits(port_state_t);

endpackage

### sv/dehed_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dehed_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dehed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port (old data on a same-address write)
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/din_edge_hold_event_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// din_edge_hold_event_detector
// Per-port edge detector with hold-time qualification on polled samples.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Contents
//  s_*       in         tvalid/tready       one sample request: port, level, time
//  m_*       out        tvalid/tready       one result per sample: port, fired
//  cfg_*     in         cfg_wen             register writes, no read-back
//
//  One sample a cycle unless m_tready stalls; state RAM read on the accept edge,
//  then compare/update; write-back and result register load as stage 1 advances.
//  The next request may hit the same port: the write-back is forwarded.
//  Reset clears port state valid bits, modes, hold times and sets slack.
//  A stall on m_tready holds the pipeline; s_tready falls only when the
//  compare stage is full and the output register cannot drain.
// ----------------------------------------------------------------------------
module din_edge_hold_event_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample stream: [2:0] port, [3] level, [35:4] time_us, [39:36] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dehed_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result stream: [2:0] event_port, [3] event_fired, [7:4] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dehed_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                              cfg_wen,
    input  logic [dehed_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dehed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import dehed_pkg::*;

    // Configuration registers
    logic [MODES_W-1:0]    port_modes_reg;
    logic [CFG_DATA_W-1:0] hold_reg [NUM_HOLD_REGS];
    logic [SLACK_W-1:0]    slack_reg;

    // Input fields
    logic [PORT_W-1:0] in_port;
    logic              in_level;
    logic [TIME_W-1:0] in_time;

    // Stage 0 decode
    port_mode_t        in_mode;
    logic [HOLD_W-1:0] in_hold;
    logic              in_hold_zero;
    logic              in_ignore;
    logic              in_match;
    logic              in_opposite;
    logic [TIME_W-1:0] in_need;
    logic              accept;

    // Compare stage registers
    logic              s1_vld_reg, s1_vld_next;
    logic [PORT_W-1:0] s1_port_reg;
    logic              s1_level_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic              s1_hold_zero_reg;
    logic              s1_ignore_reg;
    logic              s1_match_reg;
    logic              s1_opposite_reg;
    logic [TIME_W-1:0] s1_need_reg;

    // State memory and forwarding
    logic [NUM_PORTS-1:0]  valid_reg, valid_next;
    logic                  fwd_hit_reg;
    port_state_t           fwd_data_reg;
    port_state_t           ram_rdata;
    port_state_t           cur;
    port_state_t           upd;
    logic                  wr_en;
    logic [PORT_IDX_W-1:0] wr_addr;
    logic [PORT_IDX_W-1:0] rd_addr;
    logic [PORT_IDX_W-1:0] s1_idx;

    // Update logic
    logic                  changed;
    logic                  fired;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W:0]       elapsed_slack;
    logic                  due;
    logic                  adv;

    // Output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [PORT_W-1:0]     m_port_reg;
    logic                  m_fired_reg;

    assign in_port  = s_tdata[PORT_W-1:0];
    assign in_level = s_tdata[PORT_W];
    assign in_time  = s_tdata[PORT_W+1 +: TIME_W];

    // ------------------------------------------------------------------
    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_modes_reg <= '0;
            for (int i = 0; i < NUM_HOLD_REGS; i++)
            begin
                hold_reg[i] <= '0;
            end
            slack_reg <= SLACK_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_PORT_MODES: port_modes_reg <= cfg_wdata[MODES_W-1:0];
                CFG_HOLD_01:    hold_reg[0]    <= cfg_wdata;
                CFG_HOLD_23:    hold_reg[1]    <= cfg_wdata;
                CFG_HOLD_45:    hold_reg[2]    <= cfg_wdata;
                CFG_HOLD_67:    hold_reg[3]    <= cfg_wdata;
                CFG_SLACK:      slack_reg      <= cfg_wdata[SLACK_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: mode and hold lookup, hold time scaled to microseconds
    always_comb
    begin
        in_mode = port_mode_t'(port_modes_reg[{in_port, 1'b0} +: 2]);
        in_hold = in_port[0] ? hold_reg[in_port[2:1]][CFG_DATA_W-1:HOLD_W]
                             : hold_reg[in_port[2:1]][HOLD_W-1:0];
        in_hold_zero = (in_hold == '0);
        in_ignore = ({1'b0, in_port} >= (PORT_W+1)'(NUM_PORTS))
                 || (in_mode == MODE_CLEAR)
                 || (!in_hold_zero && ((in_hold < HOLD_MIN_MS) || (in_hold > HOLD_MAX_MS)));
        in_match = (in_mode == MODE_ANY)
                || ((in_mode == MODE_RISE) && in_level)
                || ((in_mode == MODE_FALL) && !in_level);
        in_opposite = ((in_mode == MODE_RISE) && !in_level)
                   || ((in_mode == MODE_FALL) && in_level);
        // x1000 = x1024 - x16 - x8; fits 32 bits for any valid hold time
        in_need = (in_hold << 10) - (in_hold << 4) - (in_hold << 3);
    end

    // ------------------------------------------------------------------
    // Handshake and stage advance
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = !s1_vld_reg || adv;
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = in_port[PORT_IDX_W-1:0];

    always_comb
    begin
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (adv)
        begin
            s1_vld_next = 1'b0;
        end
        else
        begin
            s1_vld_next = s1_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            if (accept)
            begin
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_port_reg      <= in_port;
            s1_level_reg     <= in_level;
            s1_time_reg      <= in_time;
            s1_hold_zero_reg <= in_hold_zero;
            s1_ignore_reg    <= in_ignore;
            s1_match_reg     <= in_match;
            s1_opposite_reg  <= in_opposite;
            s1_need_reg      <= in_need;
        end
        if (wr_en)
        begin
            fwd_data_reg <= upd;
        end
    end

    // ------------------------------------------------------------------
    // Per-port state RAM
    dehed_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_PORTS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (upd),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: current state with forwarding, compare and update
    assign s1_idx = s1_port_reg[PORT_IDX_W-1:0];

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (valid_reg[s1_idx])
        begin
            cur = ram_rdata;
        end
        else
        begin
            cur = ram_rdata;
            cur.timing_active = 1'b0;
            cur.last_level    = 1'b0;
        end
    end

    assign changed       = (s1_level_reg != cur.last_level);
    assign elapsed       = s1_time_reg - cur.arm_time;
    assign elapsed_slack = {1'b0, elapsed} + (TIME_W+1)'(slack_reg);
    assign due           = (elapsed_slack >= {1'b0, s1_need_reg});

    always_comb
    begin
        upd   = cur;
        fired = 1'b0;
        if (s1_hold_zero_reg)
        begin
            fired          = changed && s1_match_reg;
            upd.last_level = s1_level_reg;
        end
        else if (changed)
        begin
            if (s1_match_reg)
            begin
                upd.arm_time      = s1_time_reg;
                upd.timing_active = 1'b1;
            end
            else if (s1_opposite_reg)
            begin
                upd.timing_active = 1'b0;
            end
            upd.last_level = s1_level_reg;
        end
        else if (cur.timing_active && due)
        begin
            fired             = 1'b1;
            upd.timing_active = 1'b0;
        end
        if (s1_ignore_reg)
        begin
            fired = 1'b0;
        end
    end

    assign wr_en   = s1_vld_reg && adv && !s1_ignore_reg;
    assign wr_addr = s1_idx;

    // Valid bits: an unwritten entry reads as idle and low
    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    assign m_tvalid_next = adv ? s1_vld_reg : m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_vld_reg)
        begin
            m_port_reg  <= s1_port_reg;
            m_fired_reg <= fired;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-PORT_W-1){1'b0}}, m_fired_reg, m_port_reg};

    // ------------------------------------------------------------------
    // Assertions
    a_wr_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_vld_reg && adv))
        else $error("state write without a leaving request");

    a_fwd_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg && !s1_vld_reg |-> !$past(accept))
        else $error("forward hit recorded for an empty compare stage");

    a_ignored_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && s1_ignore_reg |-> !fired && !wr_en)
        else $error("ignored sample fired or changed state");

    a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(wr_addr)])
        else $error("valid bit not set after state write");

    a_timing_starts_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && upd.timing_active && !cur.timing_active |-> changed && !s1_hold_zero_reg)
        else $error("timing started without a matching change");

endmodule
